[hdl/zmca_pkg.sv]
// ----------------------------------------------------------------------------
// Zone mean colour averager package
// Shared types, constants and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package zmca_pkg;

    localparam int MAX_LINE_WIDTH_DEF = 4096;
    localparam int NUM_ZONES_DEF      = 9;
    localparam int MAX_HALF_SIZE_DEF  = 200;
    localparam int MIN_HALF_SIZE      = 5;
    localparam int COORD_W            = 12;
    localparam int SUM_W              = 26;
    localparam int CNT_W              = 18;
    localparam int ZONES              = 9;
    localparam int ZONE_W             = 4;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [COORD_W-1:0] ROW_MAX = {COORD_W{1'b1}};

    localparam logic [2:0] REG_TL = 3'd0;
    localparam logic [2:0] REG_TR = 3'd1;
    localparam logic [2:0] REG_BL = 3'd2;
    localparam logic [2:0] REG_BR = 3'd3;
    localparam logic [2:0] REG_HS = 3'd4;

    localparam logic [23:0] TL_RESET = 24'd0;
    localparam logic [23:0] TR_RESET = 24'd639;
    localparam logic [23:0] BL_RESET = 24'd1961984;
    localparam logic [23:0] BR_RESET = 24'd1962623;
    localparam logic [7:0]  HS_RESET = 8'd20;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       line_end;
        logic       frame_end;
    } pixel_t;

    typedef struct packed {
        logic [3:0] zone_index;
        logic [7:0] mean_red;
        logic [7:0] mean_green;
        logic [7:0] mean_blue;
        logic       last_zone;
    } zone_result_t;

    typedef struct packed {
        logic [3:0]       zone;
        logic [SUM_W-1:0] red_sum;
        logic [SUM_W-1:0] green_sum;
        logic [SUM_W-1:0] blue_sum;
        logic [CNT_W-1:0] count;
    } zone_total_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_OUT
    } div_state_t;

    // Midpoint a + floor((b - a + 1) / 2) on signed 14-bit values.
    function automatic logic signed [13:0] midpoint(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
        logic signed [13:0] d;
        d = $signed({2'b00, b}) - $signed({2'b00, a}) + 14'sd1;
        return $signed({2'b00, a}) + (d >>> 1);
    endfunction

endpackage

`default_nettype wire

[hdl/zone_mean_color_averager.sv]
// ----------------------------------------------------------------------------
// Zone mean colour averager
// Sums RGB pixels over nine square windows and reports their means per frame.
// ----------------------------------------------------------------------------
// One pixel is accepted per clock while input is not stalled. On the frame end
// pixel the nine zone totals are moved into a sixteen-entry queue, during
// which input is stalled; a divider then produces the results one at a time,
// each through load, 26 quotient steps and output, overlapping the next frame.
// Input also stalls while the queue cannot take nine more totals.
`default_nettype none

module zone_mean_color_averager
    import zmca_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire pixel_t       in_data,
    output logic              out_valid,
    input  wire logic         out_stall,
    output zone_result_t      out_data,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [23:0] tl_reg, tr_reg, bl_reg, br_reg;
    logic [7:0]  hs_reg, hs_next;
    logic        wr;
    logic [2:0]  idx;
    logic        q_push, q_pop, q_ne, q_space9;
    zone_total_t q_wdata, q_rdata;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[4:2];

    always_comb
    begin
        hs_next = pwdata[7:0];
        if (pwdata[7:0] < 8'(MIN_HALF_SIZE))
            hs_next = 8'(MIN_HALF_SIZE);
        else if (pwdata[7:0] > 8'(MAX_HALF_SIZE_DEF))
            hs_next = 8'(MAX_HALF_SIZE_DEF);
    end

    always_comb
    begin
        case (idx)
            REG_TL:  prdata = {8'd0, tl_reg};
            REG_TR:  prdata = {8'd0, tr_reg};
            REG_BL:  prdata = {8'd0, bl_reg};
            REG_BR:  prdata = {8'd0, br_reg};
            REG_HS:  prdata = {24'd0, hs_reg};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tl_reg <= TL_RESET;
            tr_reg <= TR_RESET;
            bl_reg <= BL_RESET;
            br_reg <= BR_RESET;
            hs_reg <= HS_RESET;
        end
        else if (wr)
        begin
            case (idx)
                REG_TL:  tl_reg <= pwdata[23:0];
                REG_TR:  tr_reg <= pwdata[23:0];
                REG_BL:  bl_reg <= pwdata[23:0];
                REG_BR:  br_reg <= pwdata[23:0];
                REG_HS:  hs_reg <= hs_next;
                default: ;
            endcase
        end
    end

    zmca_accum #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_accum (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .tl(tl_reg), .tr(tr_reg), .bl(bl_reg), .br(br_reg), .half(hs_reg),
        .q_push(q_push), .q_data(q_wdata), .q_space9(q_space9)
    );

    zmca_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(q_push), .wdata(q_wdata), .pop(q_pop), .rdata(q_rdata),
        .not_empty(q_ne), .space9(q_space9)
    );

    zmca_divider u_div (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_ne), .q_data(q_rdata), .q_pop(q_pop),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

endmodule

`default_nettype wire

[hdl/zmca_accum.sv]
// ----------------------------------------------------------------------------
// Zone accumulator
// Counts pixel position and sums pixels in the nine zone windows; at frame
// end it pushes the nine totals into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module zmca_accum
    import zmca_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire pixel_t       in_data,
    input  wire logic [23:0]  tl,
    input  wire logic [23:0]  tr,
    input  wire logic [23:0]  bl,
    input  wire logic [23:0]  br,
    input  wire logic [7:0]   half,
    output logic              q_push,
    output zone_total_t       q_data,
    input  wire logic         q_space9
);

    localparam logic [COORD_W-1:0] COL_MAX = COORD_W'(MAX_LINE_WIDTH - 1);

    logic [COORD_W-1:0] col_reg, col_next, row_reg, row_next;
    logic [SUM_W-1:0]   rs_reg [ZONES];
    logic [SUM_W-1:0]   gs_reg [ZONES];
    logic [SUM_W-1:0]   bs_reg [ZONES];
    logic [CNT_W-1:0]   cn_reg [ZONES];
    logic               dump_reg, dump_next;
    logic [3:0]         dz_reg, dz_next;
    logic signed [13:0] px [ZONES];
    logic signed [13:0] py [ZONES];
    logic [ZONES-1:0]   hit;
    logic               acc;

    always_comb
    begin
        px[0] = $signed({2'b00, tl[11:0]});  py[0] = $signed({2'b00, tl[23:12]});
        px[1] = midpoint(tl[11:0], tr[11:0]); py[1] = midpoint(tl[23:12], tr[23:12]);
        px[2] = $signed({2'b00, tr[11:0]});  py[2] = $signed({2'b00, tr[23:12]});
        px[3] = midpoint(tl[11:0], bl[11:0]); py[3] = midpoint(tl[23:12], bl[23:12]);
        px[4] = midpoint(tl[11:0], br[11:0]); py[4] = midpoint(tl[23:12], br[23:12]);
        px[5] = midpoint(tr[11:0], br[11:0]); py[5] = midpoint(tr[23:12], br[23:12]);
        px[6] = $signed({2'b00, bl[11:0]});  py[6] = $signed({2'b00, bl[23:12]});
        px[7] = midpoint(bl[11:0], br[11:0]); py[7] = midpoint(bl[23:12], br[23:12]);
        px[8] = $signed({2'b00, br[11:0]});  py[8] = $signed({2'b00, br[23:12]});
    end

    always_comb
    begin
        logic signed [14:0] x, y, hh, cx, cy;
        x  = $signed({3'b000, col_reg});
        y  = $signed({3'b000, row_reg});
        hh = $signed({7'd0, half});
        for (int i = 0; i < ZONES; i++)
        begin
            cx = 15'(px[i]);
            cy = 15'(py[i]);
            hit[i] = (x >= cx - hh) && (x < cx + hh) && (y >= cy - hh) && (y < cy + hh)
                     && (cn_reg[i] != COUNT_MAX);
        end
    end

    assign in_stall = dump_reg || !q_space9;
    assign acc      = in_valid && !in_stall;

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        dump_next = dump_reg;
        dz_next   = dz_reg;
        if (dump_reg)
        begin
            dz_next = dz_reg + 4'd1;
            if (dz_reg == 4'(ZONES - 1))
            begin
                dump_next = 1'b0;
                dz_next   = '0;
            end
        end
        else if (acc)
        begin
            if (in_data.frame_end)
            begin
                dump_next = 1'b1;
                col_next  = '0;
                row_next  = '0;
            end
            else if (in_data.line_end)
            begin
                col_next = '0;
                if (row_reg != ROW_MAX)
                    row_next = row_reg + 1'b1;
            end
            else if (col_reg < COL_MAX)
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    assign q_push         = dump_reg;
    assign q_data.zone    = dz_reg;
    assign q_data.red_sum = rs_reg[dz_reg];
    assign q_data.green_sum = gs_reg[dz_reg];
    assign q_data.blue_sum  = bs_reg[dz_reg];
    assign q_data.count     = cn_reg[dz_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            dump_reg <= 1'b0;
            dz_reg   <= '0;
            for (int i = 0; i < ZONES; i++)
            begin
                rs_reg[i] <= '0;
                gs_reg[i] <= '0;
                bs_reg[i] <= '0;
                cn_reg[i] <= '0;
            end
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            dump_reg <= dump_next;
            dz_reg   <= dz_next;
            if (dump_reg)
            begin
                rs_reg[dz_reg] <= '0;
                gs_reg[dz_reg] <= '0;
                bs_reg[dz_reg] <= '0;
                cn_reg[dz_reg] <= '0;
            end
            else if (acc)
            begin
                for (int i = 0; i < ZONES; i++)
                begin
                    if (hit[i])
                    begin
                        rs_reg[i] <= rs_reg[i] + SUM_W'(in_data.red);
                        gs_reg[i] <= gs_reg[i] + SUM_W'(in_data.green);
                        bs_reg[i] <= bs_reg[i] + SUM_W'(in_data.blue);
                        cn_reg[i] <= cn_reg[i] + 1'b1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

[hdl/zmca_queue.sv]
// ----------------------------------------------------------------------------
// Zone total queue
// Sixteen-entry FIFO of zone totals between accumulator and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module zmca_queue
    import zmca_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire zone_total_t wdata,
    input  wire logic        pop,
    output zone_total_t      rdata,
    output logic             not_empty,
    output logic             space9
);

    logic [3:0]  wp_reg, rp_reg;
    logic [4:0]  fill_reg;
    zone_total_t mem [16];

    assign rdata     = mem[rp_reg];
    assign not_empty = fill_reg != 5'd0;
    assign space9    = fill_reg <= 5'(16 - ZONES);

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 4'd1;
            if (pop)
                rp_reg <= rp_reg + 4'd1;
            fill_reg <= fill_reg + 5'(push) - 5'(pop);
        end
    end

endmodule

`default_nettype wire

[hdl/zmca_divider.sv]
// ----------------------------------------------------------------------------
// Zone mean divider
// Restoring division of the three channel sums by the pixel count, one
// quotient bit per cycle, and an output register for the result.
// ----------------------------------------------------------------------------
`default_nettype none

module zmca_divider
    import zmca_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire zone_total_t q_data,
    output logic             q_pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output zone_result_t     out_data
);

    div_state_t         st_reg, st_next;
    logic [SUM_W-1:0]   nr_reg [3];
    logic [CNT_W:0]     rm_reg [3];
    logic [CNT_W-1:0]   dv_reg;
    logic [3:0]         zn_reg;
    logic [4:0]         step_reg;
    logic [CNT_W:0]     trial [3];
    logic [CNT_W:0]     sub   [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            trial[c] = {rm_reg[c][CNT_W-1:0], nr_reg[c][SUM_W-1]};
            sub[c]   = trial[c] - {1'b0, dv_reg};
        end
    end

    always_comb
    begin
        st_next = st_reg;
        q_pop   = 1'b0;
        case (st_reg)
            DIV_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop   = 1'b1;
                    st_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (step_reg == 5'(SUM_W - 1))
                    st_next = DIV_OUT;
            end
            DIV_OUT:
            begin
                if (!out_stall)
                    st_next = DIV_IDLE;
            end
            default: st_next = DIV_IDLE;
        endcase
    end

    assign out_valid           = st_reg == DIV_OUT;
    assign out_data.zone_index = zn_reg;
    assign out_data.last_zone  = zn_reg == 4'(ZONES - 1);
    assign out_data.mean_red   = (dv_reg == '0) ? 8'd0 : nr_reg[0][7:0];
    assign out_data.mean_green = (dv_reg == '0) ? 8'd0 : nr_reg[1][7:0];
    assign out_data.mean_blue  = (dv_reg == '0) ? 8'd0 : nr_reg[2][7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= DIV_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == DIV_IDLE && q_valid)
        begin
            nr_reg[0] <= q_data.red_sum;
            nr_reg[1] <= q_data.green_sum;
            nr_reg[2] <= q_data.blue_sum;
            for (int c = 0; c < 3; c++)
                rm_reg[c] <= '0;
            dv_reg   <= q_data.count;
            zn_reg   <= q_data.zone;
            step_reg <= '0;
        end
        else if (st_reg == DIV_RUN)
        begin
            step_reg <= step_reg + 5'd1;
            for (int c = 0; c < 3; c++)
            begin
                if (!sub[c][CNT_W])
                begin
                    rm_reg[c] <= sub[c];
                    nr_reg[c] <= {nr_reg[c][SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rm_reg[c] <= trial[c];
                    nr_reg[c] <= {nr_reg[c][SUM_W-2:0], 1'b0};
                end
            end
        end
    end

endmodule

`default_nettype wire

[hdl/zmca_checker.sv]
// ----------------------------------------------------------------------------
// Zone mean colour averager checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module zmca_checker
    import zmca_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         out_valid,
    input wire logic         out_stall,
    input wire zone_result_t out_data,
    input wire logic         pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("Stalled transaction changed.");

    a_zone_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.zone_index <= 4'(ZONES - 1))
        else $error("Zone index out of range.");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.last_zone == (out_data.zone_index == 4'(ZONES - 1)))
        else $error("Last zone flag wrong.");

    a_ready: assert property (@(posedge clk) pready)
        else $error("pready low.");

endmodule

bind zone_mean_color_averager zmca_checker u_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .pready(pready)
);

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Zone mean colour averager testbench
// Drives short frames of random or patterned pixels through the averager.
// Corners and window size are written over the register port between
// frames. A predictor works out the nine zone means of each frame. Every
// result is compared against the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import zmca_pkg::*;

    class zone_mean_scoreboard;
        logic [23:0] corner[4];
        logic [7:0]  half_size;
        int unsigned column;
        int unsigned row;
        int unsigned red_total[ZONES];
        int unsigned green_total[ZONES];
        int unsigned blue_total[ZONES];
        int unsigned pixel_total[ZONES];
        zone_result_t expected_means[$];
        int errors;

        function void clear_frame();
            column = 0;
            row = 0;
            for (int i = 0; i < ZONES; i++)
            begin
                red_total[i] = 0;
                green_total[i] = 0;
                blue_total[i] = 0;
                pixel_total[i] = 0;
            end
        endfunction

        function void reset_state();
            corner[REG_TL] = TL_RESET;
            corner[REG_TR] = TR_RESET;
            corner[REG_BL] = BL_RESET;
            corner[REG_BR] = BR_RESET;
            half_size = HS_RESET;
            errors = 0;
            clear_frame();
        endfunction

        function void write_register(logic [2:0] index, logic [31:0] value);
            int unsigned h;
            h = value[7:0];
            if (index == REG_HS)
            begin
                if (h < MIN_HALF_SIZE)
                    h = MIN_HALF_SIZE;
                if (h > MAX_HALF_SIZE_DEF)
                    h = MAX_HALF_SIZE_DEF;
                half_size = 8'(h);
            end
            else if (index <= REG_BR)
                corner[index] = value[23:0];
        endfunction

        function int round_half_up(int d);
            int n;
            n = d + 1;
            return (n >= 0) ? n / 2 : -((-n + 1) / 2);
        endfunction

        function int between(int a, int b);
            return a + round_half_up(b - a);
        endfunction

        function void note_pixel(pixel_t p);
            int px[ZONES];
            int py[ZONES];
            int cx[4];
            int cy[4];
            int h;
            int x;
            int y;
            zone_result_t r;
            for (int i = 0; i < 4; i++)
            begin
                cx[i] = corner[i][11:0];
                cy[i] = corner[i][23:12];
            end
            px[0] = cx[0];                 py[0] = cy[0];
            px[1] = between(cx[0], cx[1]); py[1] = between(cy[0], cy[1]);
            px[2] = cx[1];                 py[2] = cy[1];
            px[3] = between(cx[0], cx[2]); py[3] = between(cy[0], cy[2]);
            px[4] = between(cx[0], cx[3]); py[4] = between(cy[0], cy[3]);
            px[5] = between(cx[1], cx[3]); py[5] = between(cy[1], cy[3]);
            px[6] = cx[2];                 py[6] = cy[2];
            px[7] = between(cx[2], cx[3]); py[7] = between(cy[2], cy[3]);
            px[8] = cx[3];                 py[8] = cy[3];
            h = half_size;
            x = column;
            y = row;
            for (int i = 0; i < ZONES; i++)
            begin
                if (x >= px[i] - h && x < px[i] + h && y >= py[i] - h && y < py[i] + h
                    && pixel_total[i] < COUNT_MAX)
                begin
                    red_total[i] += p.red;
                    green_total[i] += p.green;
                    blue_total[i] += p.blue;
                    pixel_total[i]++;
                end
            end
            if (p.frame_end)
            begin
                for (int i = 0; i < ZONES; i++)
                begin
                    r.zone_index = 4'(i);
                    r.mean_red = pixel_total[i] ? 8'(red_total[i] / pixel_total[i]) : 8'd0;
                    r.mean_green = pixel_total[i] ? 8'(green_total[i] / pixel_total[i]) : 8'd0;
                    r.mean_blue = pixel_total[i] ? 8'(blue_total[i] / pixel_total[i]) : 8'd0;
                    r.last_zone = (i == ZONES - 1);
                    expected_means.push_back(r);
                end
                clear_frame();
            end
            else if (p.line_end)
            begin
                column = 0;
                if (row < ROW_MAX)
                    row++;
            end
            else if (column < MAX_LINE_WIDTH_DEF - 1)
                column++;
        endfunction

        function void check_result(zone_result_t got);
            zone_result_t want;
            if (expected_means.size() == 0)
            begin
                $error("unexpected result transaction: %p", got);
                errors++;
                return;
            end
            want = expected_means.pop_front();
            if (got.zone_index !== want.zone_index)
            begin
                $error("zone_index expected %0d actual %0d", want.zone_index, got.zone_index);
                errors++;
            end
            if (got.mean_red !== want.mean_red)
            begin
                $error("mean_red expected %0d actual %0d", want.mean_red, got.mean_red);
                errors++;
            end
            if (got.mean_green !== want.mean_green)
            begin
                $error("mean_green expected %0d actual %0d", want.mean_green, got.mean_green);
                errors++;
            end
            if (got.mean_blue !== want.mean_blue)
            begin
                $error("mean_blue expected %0d actual %0d", want.mean_blue, got.mean_blue);
                errors++;
            end
            if (got.last_zone !== want.last_zone)
            begin
                $error("last_zone expected %0d actual %0d", want.last_zone, got.last_zone);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_stall;
    pixel_t       in_data;
    logic         out_valid;
    logic         out_stall;
    zone_result_t out_data;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    zone_mean_scoreboard zone_means;
    int  send_idle_pct;
    int  stall_pct;
    int  hold_off_cycles;
    longint cycle_count;

    zone_mean_color_averager dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("zone_mean_color_averager: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            zone_means.check_result(out_data);

    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic write_register(logic [2:0] index, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        zone_means.write_register(index, value);
    endtask

    task automatic send_pixel(pixel_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        zone_means.note_pixel(p);
        @(negedge clk);
    endtask

    task automatic send_frame(int width, int height, bit extreme);
        pixel_t p;
        for (int y = 0; y < height; y++)
            for (int x = 0; x < width; x++)
            begin
                p.red = extreme ? (((x + y) & 1) ? 8'hff : 8'h00) : 8'($urandom);
                p.green = extreme ? ((x & 1) ? 8'h00 : 8'hff) : 8'($urandom);
                p.blue = 8'($urandom);
                p.line_end = (x == width - 1);
                p.frame_end = (x == width - 1) && (y == height - 1);
                if ($urandom_range(99) < 3)
                    p.line_end = ~p.line_end;
                send_pixel(p);
            end
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (zone_means.expected_means.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic random_setup();
        logic [31:0] v;
        for (int i = 0; i < 4; i++)
        begin
            v = $urandom;
            if ($urandom_range(3) != 0)
                v[23:0] = {12'($urandom_range(14)), 12'($urandom_range(14))};
            write_register(i[2:0], v);
        end
        v = $urandom;
        if ($urandom_range(1))
            v[7:0] = 8'($urandom_range(9));
        write_register(REG_HS, v);
    endtask

    initial
    begin
        zone_means = new();
        zone_means.reset_state();
        cycle_count = 0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        send_frame(3, 2, 1'b1);
        wait_drained();
        write_register(REG_TL, 32'hffff_ffff);
        write_register(REG_TR, 32'h0000_0000);
        write_register(REG_BL, 32'h0000_3004);
        write_register(REG_BR, 32'h0000_4003);
        write_register(REG_HS, 32'h0000_00ff);
        write_register(3'd7, 32'h0000_0001);
        send_frame(4, 3, 1'b1);
        wait_drained();
        write_register(REG_TL, 32'h0000_0000);
        write_register(REG_HS, 32'h0000_0000);
        send_frame(4, 2, 1'b0);
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 74 : 0;
            stall_pct = (phase == 0) ? 74 : (phase == 1) ? 20 : 0;
            for (int f = 0; f < 6; f++)
            begin
                if (f == 2)
                    hold_off_cycles = 600;
                random_setup();
                send_frame($urandom_range(1, 6), $urandom_range(1, 5), 1'b0);
                send_frame($urandom_range(1, 5), $urandom_range(1, 4), 1'b0);
                if (f == 4)
                    wait_drained();
                else
                    while (zone_means.expected_means.size() != 0)
                        @(negedge clk);
                wait_drained();
            end
        end

        wait_drained();
        if (zone_means.errors == 0 && zone_means.expected_means.size() == 0)
            $display("zone_mean_color_averager: match");
        else
            $display("zone_mean_color_averager: mismatch");
        $finish;
    end
endmodule

[zone_mean_color_averager.f]
hdl/zmca_pkg.sv
hdl/zmca_accum.sv
hdl/zmca_queue.sv
hdl/zmca_divider.sv
hdl/zone_mean_color_averager.sv
hdl/zmca_checker.sv
sim/testbench.sv
